// ----- sv/iet_pkg.sv -----
`timescale 1ns / 1ps

package iet_pkg;

  // Default geometry of the table
  localparam int unsigned DepthDef = 256;
  localparam int unsigned WidthDef = 32;

  // Command codes
  localparam logic [2:0] CMD_APPEND = 3'd0;
  localparam logic [2:0] CMD_INSERT = 3'd1;
  localparam logic [2:0] CMD_REMOVE = 3'd2;
  localparam logic [2:0] CMD_SWAP   = 3'd3;
  localparam logic [2:0] CMD_FIND   = 3'd4;
  localparam logic [2:0] CMD_READ   = 3'd5;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  index;
    logic [7:0]  index_b;
    logic [31:0] value;
  } iet_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  found_index;
    logic [31:0] read_data;
    logic [8:0]  fill_count;
  } iet_rsp_t;

endpackage

// ----- sv/indexed_element_table.sv -----
`timescale 1ns / 1ps

// Indexed element table: a packed table of up to DEPTH entries of WIDTH bits
// held in one single-port-write, single-port-read RAM with a registered
// read, plus a fill count. Each request carries one command and gives
// exactly one response with status, found index, read data and the fill count
// after the command. Requests are taken one at a time; a finished response
// waits in an output register so the next request can be taken meanwhile.
// Append writes the new entry at once; read fetches one entry; swap reads
// both entries, then writes each to the other's place. Insert walks the
// entries from the top down to the index, moving each up by one, then
// writes the new entry; remove walks them from above the index to the top,
// moving each down by one, or only lowers the count for the last entry.
// Find reads from entry 0 up until the first match or the last entry.
// Walks move one entry per cycle. A bad index, a full table, an unknown
// command or a find on an empty table only gives the status response.
// Entries above the fill count are never read, so the RAM needs no clearing
// pass after reset.
module indexed_element_table
  import iet_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDef,
  parameter int unsigned WIDTH = WidthDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  iet_req_t req_i,
  output logic     rsp_valid_o,
  input  logic     rsp_ready_i,
  output iet_rsp_t rsp_o
);

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > 8) ? CW : 8;

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MOVE  = 4'd1;  // shift entries up (insert) or down (remove)
  localparam logic [3:0] S_WRNEW = 4'd2;  // write the inserted entry
  localparam logic [3:0] S_SWAP1 = 4'd3;
  localparam logic [3:0] S_SWAP2 = 4'd4;
  localparam logic [3:0] S_SWAP3 = 4'd5;
  localparam logic [3:0] S_SWAP4 = 4'd6;
  localparam logic [3:0] S_FIND  = 4'd7;
  localparam logic [3:0] S_READ1 = 4'd8;
  localparam logic [3:0] S_READ2 = 4'd9;
  localparam logic [3:0] S_RESP  = 4'd10;

  logic [3:0]       state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    src_q, src_d;      // next RAM read address of a walk
  logic [AW-1:0]    end_q, end_d;      // last read address of a move
  logic [AW-1:0]    wa_q, wa_d;        // destination (move) or position (find) of data in flight
  logic             rd_on_q, rd_on_d;  // walk still issuing reads
  logic             rv_q, rv_d;        // RAM read data belongs to the walk
  logic [2:0]       cmd_q, cmd_d;
  logic [AW-1:0]    ia_q, ia_d;
  logic [AW-1:0]    ib_q, ib_d;
  logic [WIDTH-1:0] val_q, val_d;
  logic [WIDTH-1:0] tmp_q, tmp_d;
  logic [1:0]       st_q, st_d;
  logic [7:0]       fi_q, fi_d;
  logic [31:0]      rdat_q, rdat_d;
  logic             out_valid_q, out_valid_d;
  iet_rsp_t         out_q, out_d;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [WIDTH-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [WIDTH-1:0] ram_rdata;

  logic [CMPW-1:0]  ia_ext, ib_ext, count_ext;
  logic             req_fire;
  logic             full;

  iet_ram #(
    .Width (WIDTH),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign req_ready_o = (state_q == S_IDLE);
  assign req_fire    = req_valid_i & req_ready_o;
  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

  assign ia_ext    = CMPW'(req_i.index);
  assign ib_ext    = CMPW'(req_i.index_b);
  assign count_ext = CMPW'(count_q);
  assign full      = (count_q >= CW'(DEPTH));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    src_d       = src_q;
    end_d       = end_q;
    wa_d        = wa_q;
    rd_on_d     = rd_on_q;
    rv_d        = rv_q;
    cmd_d       = cmd_q;
    ia_d        = ia_q;
    ib_d        = ib_q;
    val_d       = val_q;
    tmp_d       = tmp_q;
    st_d        = st_q;
    fi_d        = fi_q;
    rdat_d      = rdat_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = wa_q;
    ram_wdata   = ram_rdata;
    ram_raddr   = src_q;

    // Drain the response register when the consumer takes it
    if (out_valid_q && rsp_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          cmd_d   = req_i.cmd;
          ia_d    = AW'(ia_ext);
          ib_d    = AW'(ib_ext);
          val_d   = WIDTH'(req_i.value);
          st_d    = ST_OK;
          fi_d    = '0;
          rdat_d  = '0;
          rv_d    = 1'b0;
          rd_on_d = 1'b1;
          state_d = S_RESP;
          case (req_i.cmd)
            CMD_APPEND: begin
              if (full) begin
                st_d = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = AW'(count_q);
                ram_wdata = WIDTH'(req_i.value);
                count_d   = count_q + CW'(1);
              end
            end
            CMD_INSERT: begin
              if (ia_ext >= count_ext) begin
                st_d = ST_BAD_INDEX;
              end else if (full) begin
                st_d = ST_FULL;
              end else begin
                // Walk down from the top entry to the insert position
                src_d   = AW'(count_q - CW'(1));
                end_d   = AW'(ia_ext);
                state_d = S_MOVE;
              end
            end
            CMD_REMOVE: begin
              if (ia_ext >= count_ext) begin
                st_d = ST_BAD_INDEX;
              end else if (ia_ext + CMPW'(1) == count_ext) begin
                count_d = count_q - CW'(1);
              end else begin
                // Walk up from just above the removed entry to the top
                src_d   = AW'(ia_ext + CMPW'(1));
                end_d   = AW'(count_q - CW'(1));
                state_d = S_MOVE;
              end
            end
            CMD_SWAP: begin
              if (ia_ext >= count_ext || ib_ext >= count_ext) begin
                st_d = ST_BAD_INDEX;
              end else begin
                state_d = S_SWAP1;
              end
            end
            CMD_FIND: begin
              if (count_q == '0) begin
                st_d = ST_NOT_FOUND;
              end else begin
                src_d   = '0;
                state_d = S_FIND;
              end
            end
            CMD_READ: begin
              if (ia_ext >= count_ext) begin
                st_d = ST_BAD_INDEX;
              end else begin
                state_d = S_READ1;
              end
            end
            default: begin
              // Unknown command: no effect, status ok
            end
          endcase
        end
      end

      S_MOVE: begin
        // Write back the entry read in the previous cycle
        if (rv_q) begin
          ram_we    = 1'b1;
          ram_waddr = wa_q;
          ram_wdata = ram_rdata;
        end
        if (rd_on_q) begin
          ram_raddr = src_q;
          rv_d      = 1'b1;
          if (cmd_q == CMD_INSERT) begin
            wa_d  = src_q + AW'(1);
            src_d = src_q - AW'(1);
          end else begin
            wa_d  = src_q - AW'(1);
            src_d = src_q + AW'(1);
          end
          if (src_q == end_q) begin
            rd_on_d = 1'b0;
          end
        end else begin
          rv_d = 1'b0;
          if (cmd_q == CMD_INSERT) begin
            state_d = S_WRNEW;
          end else begin
            count_d = count_q - CW'(1);
            state_d = S_RESP;
          end
        end
      end

      S_WRNEW: begin
        ram_we    = 1'b1;
        ram_waddr = ia_q;
        ram_wdata = val_q;
        count_d   = count_q + CW'(1);
        state_d   = S_RESP;
      end

      S_SWAP1: begin
        ram_raddr = ia_q;
        state_d   = S_SWAP2;
      end

      S_SWAP2: begin
        ram_raddr = ib_q;
        tmp_d     = ram_rdata;
        state_d   = S_SWAP3;
      end

      S_SWAP3: begin
        ram_we    = 1'b1;
        ram_waddr = ia_q;
        ram_wdata = ram_rdata;
        state_d   = S_SWAP4;
      end

      S_SWAP4: begin
        ram_we    = 1'b1;
        ram_waddr = ib_q;
        ram_wdata = tmp_q;
        state_d   = S_RESP;
      end

      S_FIND: begin
        if (rv_q && (ram_rdata == val_q)) begin
          // First match wins; drop any read still in flight
          fi_d    = 8'(CMPW'(wa_q));
          st_d    = ST_OK;
          rv_d    = 1'b0;
          state_d = S_RESP;
        end else if (rd_on_q) begin
          ram_raddr = src_q;
          wa_d      = src_q;
          rv_d      = 1'b1;
          if (CW'(src_q) + CW'(1) == count_q) begin
            rd_on_d = 1'b0;
          end else begin
            src_d = src_q + AW'(1);
          end
        end else begin
          st_d    = ST_NOT_FOUND;
          rv_d    = 1'b0;
          state_d = S_RESP;
        end
      end

      S_READ1: begin
        ram_raddr = ia_q;
        state_d   = S_READ2;
      end

      S_READ2: begin
        rdat_d  = 32'(ram_rdata);
        state_d = S_RESP;
      end

      S_RESP: begin
        // Hold until the response register is free
        if (!out_valid_q || rsp_ready_i) begin
          out_valid_d       = 1'b1;
          out_d.status      = st_q;
          out_d.found_index = fi_q;
          out_d.read_data   = rdat_q;
          out_d.fill_count  = 9'(count_q);
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_on_q     <= 1'b0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_on_q     <= rd_on_d;
      rv_q        <= rv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q  <= src_d;
    end_q  <= end_d;
    wa_q   <= wa_d;
    cmd_q  <= cmd_d;
    ia_q   <= ia_d;
    ib_q   <= ib_d;
    val_q  <= val_d;
    tmp_q  <= tmp_d;
    st_q   <= st_d;
    fi_q   <= fi_d;
    rdat_q <= rdat_d;
    out_q  <= out_d;
  end

endmodule

// ----- sv/iet_ram.sv -----
`timescale 1ns / 1ps

module iet_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256,
  localparam int unsigned Aw   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
